FILE: src/sms_crt_pkg.sv
// Shared types, codes and constants of the multipart SMS reassembly table.
// No dependencies; every other file of the block but the interfaces and the RAM refers to this package.
`timescale 1ns / 1ps

package sms_crt_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int MAX_PARTS = 16;
    localparam int PIDX_W    = 4;
    localparam int RECV_W    = 5;
    localparam int HANDLE_W  = 16;
    localparam int RAM_DEPTH = NUM_SLOTS * MAX_PARTS;

    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

    localparam logic       CMD_SWEEP      = 1'b1;
    localparam logic [7:0] DCS_GROUP_MASK = 8'hC0;
    localparam logic [7:0] DCS_CLASS_FLAG = 8'h10;
    localparam logic [7:0] DCS_CLASS_MASK = 8'h03;

    typedef enum logic [2:0] {
        KIND_PASS    = 3'd0,
        KIND_STORED  = 3'd1,
        KIND_DUP     = 3'd2,
        KIND_RANGE   = 3'd3,
        KIND_PART    = 3'd4,
        KIND_TIMEOUT = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_SWEEP = 2'd1,
        OP_SEG   = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [15:0] ref_number;
        logic [7:0]  part_number;
        logic [7:0]  total_parts;
        logic [63:0] sender_id;
        logic [15:0] text_handle;
        logic [31:0] sms_time;
        logic [2:0]  msg_class;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  slot;
        logic [3:0]  part_index;
        logic        present;
        logic [15:0] handle;
        logic [63:0] sender;
        logic [15:0] ref_num;
        logic [31:0] tstamp;
        logic [2:0]  msg_class;
        logic        evicted;
        logic        last;
    } result_t;

    // Message class from the general coding group of the DCS byte.
    function automatic logic [2:0] class_of(input logic [7:0] dcs);
        logic [2:0] c;
        c = 3'd0;
        if (((dcs & DCS_GROUP_MASK) == 8'h00) && ((dcs & DCS_CLASS_FLAG) != 8'h00))
        begin
            c = {1'b0, dcs[1:0] & DCS_CLASS_MASK[1:0]} + 3'd1;
        end
        return c;
    endfunction

endpackage

FILE: src/sms_crt_ifs.sv
// Handshake channel interfaces of the reassembly table: segments in,
// results out and the timeout register write. Uses no package.
`timescale 1ns / 1ps

interface sms_crt_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] now_ms;
    logic [15:0] ref_number;
    logic [7:0]  part_number;
    logic [7:0]  total_parts;
    logic [63:0] sender_id;
    logic [15:0] text_handle;
    logic [31:0] sms_time;
    logic [7:0]  dcs;
    modport source (output valid, command, now_ms, ref_number, part_number, total_parts,
                    sender_id, text_handle, sms_time, dcs, input ready);
    modport sink   (input valid, command, now_ms, ref_number, part_number, total_parts,
                    sender_id, text_handle, sms_time, dcs, output ready);
endinterface

interface sms_crt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [3:0]  part_index;
    logic        part_present;
    logic [15:0] out_handle;
    logic [63:0] out_sender;
    logic [15:0] out_ref;
    logic [31:0] out_time;
    logic [2:0]  msg_class;
    logic        slot_evicted;
    logic        last;
    modport source (output valid, kind, slot, part_index, part_present, out_handle,
                    out_sender, out_ref, out_time, msg_class, slot_evicted, last,
                    input ready);
    modport sink   (input valid, kind, slot, part_index, part_present, out_handle,
                    out_sender, out_ref, out_time, msg_class, slot_evicted, last,
                    output ready);
endinterface

interface sms_crt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: src/sms_crt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sms_crt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sms_crt_fifo.sv
// Short queue of classified items between the front and the back part.
// Depends on sms_crt_pkg for the item type.
`timescale 1ns / 1ps

module sms_crt_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sms_crt_pkg::item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output sms_crt_pkg::item_t  head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sms_crt_pkg::item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && head_valid))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && head_valid))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/sms_crt_front.sv
// Front part: accepts segment and sweep items and classifies them.
// Depends on sms_crt_pkg and the channel interfaces.
`timescale 1ns / 1ps

module sms_crt_front (
    sms_crt_in_if.sink          seg_in,
    input  logic                q_full,
    output logic                q_push,
    output sms_crt_pkg::item_t  q_item
);

    assign seg_in.ready = !q_full;
    assign q_push       = seg_in.valid && !q_full;

    always_comb
    begin
        q_item.now_ms      = seg_in.now_ms;
        q_item.ref_number  = seg_in.ref_number;
        q_item.part_number = seg_in.part_number;
        q_item.total_parts = seg_in.total_parts;
        q_item.sender_id   = seg_in.sender_id;
        q_item.text_handle = seg_in.text_handle;
        q_item.sms_time    = seg_in.sms_time;
        q_item.msg_class   = sms_crt_pkg::class_of(seg_in.dcs);
        // Segments that are not part of a concatenation bypass the table.
        if (seg_in.command == sms_crt_pkg::CMD_SWEEP)
        begin
            q_item.op = sms_crt_pkg::OP_SWEEP;
        end
        else if ((seg_in.total_parts <= 8'd1) || (seg_in.part_number == 8'd0))
        begin
            q_item.op = sms_crt_pkg::OP_PASS;
        end
        else
        begin
            q_item.op = sms_crt_pkg::OP_SEG;
        end
    end

endmodule

FILE: src/sms_crt_back.sv
// Back part: slot table, search, store, assembly and sweep sequencer.
// Depends on sms_crt_pkg, the channel interfaces and sms_crt_ram.
`timescale 1ns / 1ps

module sms_crt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         timeout_ms,
    input  logic                q_valid,
    input  sms_crt_pkg::item_t  q_item,
    output logic                q_pop,
    sms_crt_out_if.source       res_out
);

    localparam int NS = sms_crt_pkg::NUM_SLOTS;
    localparam int SW = sms_crt_pkg::SLOT_W;
    localparam int MP = sms_crt_pkg::MAX_PARTS;
    localparam int PW = sms_crt_pkg::PIDX_W;
    localparam int RW = sms_crt_pkg::RECV_W;
    localparam int AW = $clog2(sms_crt_pkg::RAM_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SWEEP_SCAN, ST_SWEEP_EMIT, ST_SEARCH, ST_ALLOC,
        ST_CHECK, ST_ASM_RD, ST_ASM_EMIT, ST_EMIT1
    } state_t;

    state_t                 state_reg;
    sms_crt_pkg::item_t     item_reg;
    sms_crt_pkg::result_t   res_reg;
    sms_crt_pkg::result_t   res_next;
    sms_crt_pkg::kind_t     pend_kind_reg;
    logic                   out_valid_reg;
    logic [SW-1:0]          scan_reg;
    logic [SW-1:0]          slot_reg;
    logic                   evicted_reg;
    logic                   match_found_reg;
    logic [SW-1:0]          match_slot_reg;
    logic                   free_found_reg;
    logic [SW-1:0]          free_slot_reg;
    logic [31:0]            best_age_reg;
    logic [SW-1:0]          best_slot_reg;
    logic [NS-1:0]          exp_reg;
    logic [PW-1:0]          asm_i_reg;

    logic                   busy_reg   [NS];
    logic [RW-1:0]          trecv_reg  [NS];
    logic [MP-1:0]          tvalid_reg [NS];
    logic [15:0]            tref_reg   [NS];
    logic [63:0]            tsender_reg[NS];
    logic [7:0]             ttotal_reg [NS];
    logic [31:0]            tstart_reg [NS];
    logic [31:0]            tfirst_reg [NS];

    logic [SW-1:0]          ti;
    logic [31:0]            t_age;
    logic                   t_match;
    logic [7:0]             idx8;
    logic                   in_range;
    logic [PW-1:0]          pidx;
    logic [MP-1:0]          cur_valid;
    logic                   dup;
    logic [RW-1:0]          recv_inc;
    logic                   complete;
    logic [SW-1:0]          alloc_slot;
    logic                   alloc_evict;
    logic [SW-1:0]          sweep_s;
    logic [NS-1:0]          exp_rest;
    logic                   asm_last;
    logic                   out_free;
    logic                   res_load;
    logic                   store_en;
    logic [15:0]            ram_rdata;

    function automatic logic [SW-1:0] lowest_set(input logic [NS-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SW'(i);
            end
        end
        return r;
    endfunction

    // One table read address, shared by the scans and the per-item work.
    always_comb
    begin
        case (state_reg)
            ST_SEARCH, ST_SWEEP_SCAN: ti = scan_reg;
            ST_SWEEP_EMIT:            ti = sweep_s;
            default:                  ti = slot_reg;
        endcase
    end

    assign sweep_s  = lowest_set(exp_reg);
    assign exp_rest = exp_reg & ~(NS'(1) << sweep_s);
    assign t_age    = item_reg.now_ms - tstart_reg[ti];
    assign t_match  = busy_reg[ti] && (tref_reg[ti] == item_reg.ref_number)
                      && (ttotal_reg[ti] == item_reg.total_parts)
                      && (tsender_reg[ti] == item_reg.sender_id);
    assign idx8      = item_reg.part_number - 8'd1;
    assign in_range  = (idx8 < 8'(MP));
    assign pidx      = idx8[PW-1:0];
    assign cur_valid = tvalid_reg[slot_reg];
    assign dup       = cur_valid[pidx];
    assign recv_inc  = trecv_reg[slot_reg] + RW'(1);
    assign complete  = (8'(recv_inc) == item_reg.total_parts);
    assign alloc_slot  = match_found_reg ? match_slot_reg :
                         (free_found_reg ? free_slot_reg : best_slot_reg);
    assign alloc_evict = !match_found_reg && !free_found_reg;
    assign asm_last  = ((8'(asm_i_reg) + 8'd1) == item_reg.total_parts);
    assign out_free  = !out_valid_reg || res_out.ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign store_en  = (state_reg == ST_CHECK) && in_range && !dup;
    assign res_load  = out_free && (((state_reg == ST_SWEEP_EMIT) && (exp_reg != '0))
                       || (state_reg == ST_ASM_EMIT) || (state_reg == ST_EMIT1));

    sms_crt_ram #(
        .WIDTH (sms_crt_pkg::HANDLE_W),
        .DEPTH (sms_crt_pkg::RAM_DEPTH)
    ) u_handles (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (AW'({slot_reg, pidx})),
        .wr_data (item_reg.text_handle),
        .rd_en   (state_reg == ST_ASM_RD),
        .rd_addr (AW'({slot_reg, asm_i_reg})),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        res_next           = res_reg;
        res_next.slot      = ti;
        res_next.part_index = '0;
        res_next.present   = 1'b0;
        res_next.handle    = '0;
        res_next.sender    = item_reg.sender_id;
        res_next.ref_num   = item_reg.ref_number;
        res_next.tstamp    = item_reg.sms_time;
        res_next.msg_class = item_reg.msg_class;
        res_next.evicted   = evicted_reg;
        res_next.last      = 1'b1;
        res_next.kind      = pend_kind_reg;
        case (state_reg)
            ST_SWEEP_EMIT:
            begin
                res_next.kind      = sms_crt_pkg::KIND_TIMEOUT;
                res_next.sender    = tsender_reg[ti];
                res_next.ref_num   = tref_reg[ti];
                res_next.tstamp    = tfirst_reg[ti];
                res_next.msg_class = '0;
                res_next.evicted   = 1'b0;
                res_next.last      = (exp_rest == '0);
            end
            ST_ASM_EMIT:
            begin
                res_next.kind       = sms_crt_pkg::KIND_PART;
                res_next.part_index = asm_i_reg;
                res_next.present    = cur_valid[asm_i_reg];
                res_next.handle     = cur_valid[asm_i_reg] ? ram_rdata : '0;
                res_next.sender     = tsender_reg[ti];
                res_next.ref_num    = tref_reg[ti];
                res_next.tstamp     = tfirst_reg[ti];
                res_next.last       = asm_last;
            end
            ST_EMIT1:
            begin
                if (pend_kind_reg == sms_crt_pkg::KIND_PASS)
                begin
                    res_next.slot    = '0;
                    res_next.handle  = item_reg.text_handle;
                    res_next.evicted = 1'b0;
                end
                else if (pend_kind_reg != sms_crt_pkg::KIND_RANGE)
                begin
                    res_next.part_index = pidx;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Sequencer and control state of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_kind_reg   <= sms_crt_pkg::KIND_PASS;
            out_valid_reg   <= 1'b0;
            scan_reg        <= '0;
            slot_reg        <= '0;
            evicted_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            exp_reg         <= '0;
            asm_i_reg       <= '0;
            for (int s = 0; s < NS; s++)
            begin
                busy_reg[s]   <= 1'b0;
                trecv_reg[s]  <= '0;
                tvalid_reg[s] <= '0;
            end
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        scan_reg        <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        case (q_item.op)
                            sms_crt_pkg::OP_SWEEP: state_reg <= ST_SWEEP_SCAN;
                            sms_crt_pkg::OP_SEG:   state_reg <= ST_SEARCH;
                            default:
                            begin
                                pend_kind_reg <= sms_crt_pkg::KIND_PASS;
                                state_reg     <= ST_EMIT1;
                            end
                        endcase
                    end
                end
                ST_SWEEP_SCAN:
                begin
                    exp_reg[ti] <= busy_reg[ti] && (t_age >= timeout_ms);
                    if (scan_reg == SW'(NS - 1))
                    begin
                        state_reg <= ST_SWEEP_EMIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_SWEEP_EMIT:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        busy_reg[sweep_s]   <= 1'b0;
                        trecv_reg[sweep_s]  <= '0;
                        tvalid_reg[sweep_s] <= '0;
                        exp_reg             <= exp_rest;
                    end
                end
                ST_SEARCH:
                begin
                    if (t_match && !match_found_reg)
                    begin
                        match_found_reg <= 1'b1;
                        match_slot_reg  <= scan_reg;
                    end
                    if (!busy_reg[ti] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= scan_reg;
                    end
                    if (scan_reg == SW'(NS - 1))
                    begin
                        state_reg <= ST_ALLOC;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_ALLOC:
                begin
                    slot_reg    <= alloc_slot;
                    evicted_reg <= alloc_evict;
                    if (!match_found_reg)
                    begin
                        busy_reg[alloc_slot]   <= 1'b1;
                        trecv_reg[alloc_slot]  <= '0;
                        tvalid_reg[alloc_slot] <= '0;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!in_range)
                    begin
                        pend_kind_reg <= sms_crt_pkg::KIND_RANGE;
                        state_reg     <= ST_EMIT1;
                    end
                    else if (dup)
                    begin
                        pend_kind_reg <= sms_crt_pkg::KIND_DUP;
                        state_reg     <= ST_EMIT1;
                    end
                    else
                    begin
                        tvalid_reg[slot_reg][pidx] <= 1'b1;
                        trecv_reg[slot_reg]        <= recv_inc;
                        if (complete)
                        begin
                            asm_i_reg <= '0;
                            state_reg <= ST_ASM_RD;
                        end
                        else
                        begin
                            pend_kind_reg <= sms_crt_pkg::KIND_STORED;
                            state_reg     <= ST_EMIT1;
                        end
                    end
                end
                ST_ASM_RD:
                begin
                    state_reg <= ST_ASM_EMIT;
                end
                ST_ASM_EMIT:
                begin
                    if (out_free)
                    begin
                        if (asm_last)
                        begin
                            busy_reg[slot_reg]   <= 1'b0;
                            trecv_reg[slot_reg]  <= '0;
                            tvalid_reg[slot_reg] <= '0;
                            state_reg            <= ST_IDLE;
                        end
                        else
                        begin
                            asm_i_reg <= asm_i_reg + 1'b1;
                            state_reg <= ST_ASM_RD;
                        end
                    end
                end
                ST_EMIT1:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload: current item, slot fields, oldest-slot tracking and result.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_SEARCH)
        begin
            if ((scan_reg == '0) || (t_age > best_age_reg))
            begin
                best_age_reg  <= t_age;
                best_slot_reg <= scan_reg;
            end
        end
        if ((state_reg == ST_ALLOC) && !match_found_reg)
        begin
            tref_reg[alloc_slot]    <= item_reg.ref_number;
            tsender_reg[alloc_slot] <= item_reg.sender_id;
            ttotal_reg[alloc_slot]  <= item_reg.total_parts;
            tstart_reg[alloc_slot]  <= item_reg.now_ms;
            tfirst_reg[alloc_slot]  <= '0;
        end
        if (store_en && (recv_inc == RW'(1)))
        begin
            tfirst_reg[slot_reg] <= item_reg.sms_time;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.kind         = res_reg.kind;
    assign res_out.slot         = res_reg.slot;
    assign res_out.part_index   = res_reg.part_index;
    assign res_out.part_present = res_reg.present;
    assign res_out.out_handle   = res_reg.handle;
    assign res_out.out_sender   = res_reg.sender;
    assign res_out.out_ref      = res_reg.ref_num;
    assign res_out.out_time     = res_reg.tstamp;
    assign res_out.msg_class    = res_reg.msg_class;
    assign res_out.slot_evicted = res_reg.evicted;
    assign res_out.last         = res_reg.last;

endmodule

FILE: src/sms_concat_reassembly_table_top.sv
// Top level of the multipart SMS reassembly table.
// Depends on sms_crt_pkg, the channel interfaces, sms_crt_front,
// sms_crt_fifo and sms_crt_back.
//
// Usage:
// The seg_in channel carries one item per decoded segment or per timeout
// sweep command. The res_out channel returns the result items that each
// input item causes, the final one of them marked by last; a sweep that
// frees no slot returns nothing. The cfg_wr channel writes the timeout in
// milliseconds; it is always ready and is meant to be written while idle.
// In the back part, a pass-through segment goes from idle straight to
// its result. A concatenated segment scans the eight slots one per
// cycle, then allocates and checks before its result. A completing
// segment then reads and emits each assembled part in turn, bound by
// the registered read of the handle memory. A sweep scans all slots,
// frees the expired ones one at a time and then finishes. The slot
// scan sets the typical rate.
// The front part takes a new item while the back part works, until the
// queue of QUEUE_DEPTH items is full. When the receiver stalls, the result
// register holds its item and the back part waits; the front keeps
// accepting into the queue. Reset empties the table and the queue and
// sets the timeout to 60000 ms; no clearing pass is needed.
`timescale 1ns / 1ps

module sms_concat_reassembly_table_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    sms_crt_in_if.sink    seg_in,
    sms_crt_out_if.source res_out,
    sms_crt_cfg_if.sink   cfg_wr
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    sms_crt_pkg::item_t q_in_item;
    sms_crt_pkg::item_t q_head_item;
    logic [31:0]        timeout_reg;

    // The timeout register takes a write at any cycle.
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= sms_crt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr.valid)
        begin
            timeout_reg <= cfg_wr.data;
        end
    end

    sms_crt_front u_front (
        .seg_in (seg_in),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in_item)
    );

    sms_crt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head_item)
    );

    sms_crt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .timeout_ms (timeout_reg),
        .q_valid    (q_valid),
        .q_item     (q_head_item),
        .q_pop      (q_pop),
        .res_out    (res_out)
    );

endmodule

FILE: src/sms_crt_checker.sv
// Port-level checks of the reassembly table's result channel, bound to
// the top level. Depends on sms_crt_pkg for the result kind codes.
`timescale 1ns / 1ps

module sms_crt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [2:0]  slot,
    input logic [3:0]  part_index,
    input logic        part_present,
    input logic [15:0] out_handle,
    input logic [2:0]  msg_class,
    input logic        last
);

    // A stalled result holds its item.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot)
        && $stable(part_index) && $stable(last))
        else $error("result changed while stalled");

    // A pass-through result stands alone and names no slot.
    a_pass_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == sms_crt_pkg::KIND_PASS)
        |-> last && (slot == 3'd0) && (part_index == 4'd0))
        else $error("pass-through result malformed");

    // A timed-out slot carries no class, no part and no handle.
    a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == sms_crt_pkg::KIND_TIMEOUT)
        |-> (msg_class == 3'd0) && !part_present && (out_handle == 16'd0))
        else $error("timeout result carries part data");

    // Only assembled parts report a received part.
    a_present_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && part_present |-> (kind == sms_crt_pkg::KIND_PART))
        else $error("part present outside assembly");

    // Stored, duplicate and out-of-range answers are single results.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == sms_crt_pkg::KIND_STORED) || (kind == sms_crt_pkg::KIND_DUP)
        || (kind == sms_crt_pkg::KIND_RANGE)) |-> last)
        else $error("single result not marked last");

endmodule

bind sms_concat_reassembly_table_top sms_crt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .kind         (res_out.kind),
    .slot         (res_out.slot),
    .part_index   (res_out.part_index),
    .part_present (res_out.part_present),
    .out_handle   (res_out.out_handle),
    .msg_class    (res_out.msg_class),
    .last         (res_out.last)
);

FILE: tb/sv/tb_sms_crt_checker.sv
// Checker for the multipart SMS reassembly table: watches the three channels,
// predicts the result items of every accepted input item and compares them.
// Depends on sms_crt_pkg and the channel interfaces in src/sms_crt_ifs.sv.
`timescale 1ns / 1ps

module tb_sms_crt_checker (
    input  logic          clk,
    input  logic          rst_n,
    sms_crt_in_if.sink    seg_mon,
    sms_crt_out_if.sink   res_mon,
    sms_crt_cfg_if.sink   cfg_mon,
    output int            fail_count,
    output int            pending_count
);

    localparam int NS = sms_crt_pkg::NUM_SLOTS;
    localparam int MP = sms_crt_pkg::MAX_PARTS;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [3:0]  part_index;
        logic        present;
        logic [15:0] handle;
        logic [63:0] sender;
        logic [15:0] ref_num;
        logic [31:0] tstamp;
        logic [2:0]  msg_class;
        logic        evicted;
        logic        last;
    } exp_res_t;

    exp_res_t expected_results[$];

    logic [31:0] tmo;
    logic        busy   [NS];
    logic [15:0] s_ref  [NS];
    logic [63:0] s_snd  [NS];
    logic [7:0]  s_tot  [NS];
    int          s_rcv  [NS];
    logic [31:0] s_start[NS];
    logic [31:0] s_first[NS];
    logic [15:0] s_valid[NS];
    logic [15:0] s_hnd  [NS][MP];

    function automatic logic [2:0] dcs_class(input logic [7:0] d);
        if ((d & sms_crt_pkg::DCS_GROUP_MASK) != 8'h00 ||
            (d & sms_crt_pkg::DCS_CLASS_FLAG) == 8'h00)
        begin
            return 3'd0;
        end
        return {1'b0, d[1:0]} + 3'd1;
    endfunction

    function automatic exp_res_t mk(input sms_crt_pkg::kind_t k, input int s, input int pi,
                                    input logic pr, input logic [15:0] h,
                                    input logic [63:0] snd, input logic [15:0] r,
                                    input logic [31:0] t, input logic [2:0] c,
                                    input logic ev);
        exp_res_t e;
        e = '{k, s[2:0], pi[3:0], pr, h, snd, r, t, c, ev, 1'b0};
        return e;
    endfunction

    // Works out the result items of one accepted input item and updates
    // the table copy the same way the block must.
    task automatic predict_reassembly();
        exp_res_t    batch[$];
        logic [31:0] now, age, best;
        logic [7:0]  part, total;
        logic [2:0]  cls;
        int          found, idx;
        logic        ev;
        now   = seg_mon.now_ms;
        part  = seg_mon.part_number;
        total = seg_mon.total_parts;
        cls   = dcs_class(seg_mon.dcs);
        ev    = 1'b0;
        found = -1;
        if (seg_mon.command == sms_crt_pkg::CMD_SWEEP)
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (busy[s] && (now - s_start[s]) >= tmo)
                begin
                    batch.push_back(mk(sms_crt_pkg::KIND_TIMEOUT, s, 0, 0, 0, s_snd[s],
                                       s_ref[s], s_first[s], 0, 0));
                    busy[s] = 0; s_rcv[s] = 0; s_valid[s] = '0;
                end
            end
        end
        else if (total <= 1 || part == 0)
        begin
            batch.push_back(mk(sms_crt_pkg::KIND_PASS, 0, 0, 0, seg_mon.text_handle,
                               seg_mon.sender_id, seg_mon.ref_number, seg_mon.sms_time,
                               cls, 0));
        end
        else
        begin
            idx = int'(part) - 1;
            for (int s = 0; s < NS && found < 0; s++)
            begin
                if (busy[s] && s_ref[s] == seg_mon.ref_number && s_tot[s] == total &&
                    s_snd[s] == seg_mon.sender_id)
                begin
                    found = s;
                end
            end
            if (found < 0)
            begin
                for (int s = 0; s < NS && found < 0; s++)
                begin
                    if (!busy[s]) found = s;
                end
                if (found < 0)
                begin
                    best  = 0;
                    found = 0;
                    for (int s = 0; s < NS; s++)
                    begin
                        age = now - s_start[s];
                        if (s == 0 || age > best)
                        begin
                            best  = age;
                            found = s;
                        end
                    end
                    ev = 1'b1;
                end
                busy[found] = 1; s_ref[found] = seg_mon.ref_number;
                s_snd[found] = seg_mon.sender_id; s_tot[found] = total;
                s_rcv[found] = 0; s_start[found] = now; s_first[found] = 0;
                s_valid[found] = '0;
            end
            if (idx >= MP)
            begin
                batch.push_back(mk(sms_crt_pkg::KIND_RANGE, found, 0, 0, 0, seg_mon.sender_id,
                                   seg_mon.ref_number, seg_mon.sms_time, cls, ev));
            end
            else if (s_valid[found][idx])
            begin
                batch.push_back(mk(sms_crt_pkg::KIND_DUP, found, idx, 0, 0, seg_mon.sender_id,
                                   seg_mon.ref_number, seg_mon.sms_time, cls, ev));
            end
            else
            begin
                s_valid[found][idx] = 1'b1;
                s_hnd[found][idx] = seg_mon.text_handle;
                s_rcv[found]++;
                if (s_rcv[found] == 1) s_first[found] = seg_mon.sms_time;
                if (s_rcv[found] < int'(total))
                begin
                    batch.push_back(mk(sms_crt_pkg::KIND_STORED, found, idx, 0, 0,
                                       seg_mon.sender_id, seg_mon.ref_number,
                                       seg_mon.sms_time, cls, ev));
                end
                else
                begin
                    // Completion lists every part position, missing ones marked.
                    for (int i = 0; i < int'(total) && i < MP; i++)
                    begin
                        batch.push_back(mk(sms_crt_pkg::KIND_PART, found, i,
                                           s_valid[found][i],
                                           s_valid[found][i] ? s_hnd[found][i] : 16'h0,
                                           s_snd[found], s_ref[found], s_first[found],
                                           cls, ev));
                    end
                    busy[found] = 0; s_rcv[found] = 0; s_valid[found] = '0;
                end
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_results.push_back(batch[i]);
    endtask

    task automatic compare_result();
        exp_res_t e, a;
        a = '{res_mon.kind, res_mon.slot, res_mon.part_index, res_mon.part_present,
              res_mon.out_handle, res_mon.out_sender, res_mon.out_ref, res_mon.out_time,
              res_mon.msg_class, res_mon.slot_evicted, res_mon.last};
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result item %h", $time, a);
            fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (a !== e)
        begin
            $display("%0t: mismatch expected %h actual %h", $time, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo           = sms_crt_pkg::TIMEOUT_RESET;
            fail_count    = 0;
            pending_count = 0;
            expected_results.delete();
            for (int s = 0; s < NS; s++)
            begin
                busy[s] = 0; s_rcv[s] = 0; s_valid[s] = '0;
                s_start[s] = 0; s_first[s] = 0;
            end
        end
        else
        begin
            if (res_mon.valid && res_mon.ready) compare_result();
            if (seg_mon.valid && seg_mon.ready) predict_reassembly();
            if (cfg_mon.valid && cfg_mon.ready) tmo = cfg_mon.data;
            pending_count = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_sms_concat_reassembly_table_top.sv
// Testbench top of the multipart SMS reassembly table: drives segments,
// sweeps and timeout writes under random idling and gives the verdict.
// Depends on sms_crt_pkg, the channel interfaces and tb_sms_crt_checker.
`timescale 1ns / 1ps

module tb_sms_concat_reassembly_table_top;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_sink;
    int   quiet_cycles;
    int   accepted_total;

    sms_crt_in_if  seg_ch();
    sms_crt_out_if res_ch();
    sms_crt_cfg_if cfg_ch();

    sms_concat_reassembly_table_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_ch.sink),
        .res_out (res_ch.source),
        .cfg_wr  (cfg_ch.sink)
    );

    tb_sms_crt_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .seg_mon       (seg_ch.sink),
        .res_mon       (res_ch.sink),
        .cfg_mon       (cfg_ch.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // A small pool of senders and references so that segments of one
    // message meet again and slots really fill up, match and get evicted.
    logic [63:0] sender_pool[4];
    logic [31:0] now_ms;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver stalls at random unless a long hold-off is running.
    always @(posedge clk)
    begin
        res_ch.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: counts cycles in which no item moves on any channel. The
    // longest correct quiet stretch is the receiver hold-off, well below
    // this limit.
    always @(posedge clk)
    begin
        if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000)
        begin
            $display("sms_concat_reassembly_table_top regression: fail");
            $finish;
        end
    end

    // Offers one item and holds it until the block accepts it. The sender
    // idles for a random gap first, as the current idling mix asks. Valid
    // stays high after acceptance until the next gap or a drain drops it.
    task automatic send_item(input logic cmd, input logic [15:0] ref_n,
                             input logic [7:0] part, input logic [7:0] total,
                             input logic [63:0] snd, input logic [7:0] dcs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seg_ch.valid       <= 1'b1;
        seg_ch.command     <= cmd;
        seg_ch.now_ms      <= now_ms;
        seg_ch.ref_number  <= ref_n;
        seg_ch.part_number <= part;
        seg_ch.total_parts <= total;
        seg_ch.sender_id   <= snd;
        seg_ch.text_handle <= 16'($urandom());
        seg_ch.sms_time    <= $urandom();
        seg_ch.dcs         <= dcs;
        @(posedge clk);
        while (!seg_ch.ready) @(posedge clk);
        accepted_total++;
        now_ms = now_ms + $urandom_range(3000);
    endtask

    // Waits until every predicted result has arrived, then lets the back
    // part finish any scan that produces nothing before touching the register.
    task automatic drain();
        seg_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One message: its parts in random order, sometimes with a repeat,
    // sometimes only partly delivered so slots stay open.
    task automatic send_message();
        logic [15:0] ref_n;
        logic [7:0]  total;
        logic [63:0] snd;
        logic [7:0]  dcs;
        int          order[$];
        int          cut;
        ref_n = 16'($urandom_range(3));
        snd   = sender_pool[$urandom_range(3)];
        total = ($urandom_range(9) == 0) ? 8'd16 : 8'($urandom_range(2, 5));
        dcs   = 8'($urandom());
        for (int i = 1; i <= total; i++) order.push_back(i);
        order.shuffle();
        cut = ($urandom_range(3) == 0) ? $urandom_range(1, total) : total;
        for (int i = 0; i < cut; i++)
        begin
            send_item(1'b0, ref_n, 8'(order[i]), total, snd, dcs);
            if ($urandom_range(9) == 0) send_item(1'b0, ref_n, 8'(order[i]), total, snd, dcs);
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(3))
            0: send_item(1'b1, 16'd0, 8'd0, 8'd0, 64'd0, 8'd0);
            1: send_item(1'b0, 16'($urandom()), 8'($urandom_range(1)), 8'($urandom()),
                         {$urandom(), $urandom()}, 8'($urandom()));
            2: send_item(1'b0, 16'($urandom_range(3)), 8'($urandom_range(17, 255)),
                         8'($urandom_range(2, 255)), sender_pool[$urandom_range(3)],
                         8'($urandom()));
            default: send_item(1'b0, 16'($urandom()), 8'($urandom()), 8'($urandom()),
                               {$urandom(), $urandom()}, 8'($urandom()));
        endcase
    endtask

    task automatic random_phase(input int n_items);
        int start;
        start = accepted_total;
        while (accepted_total - start < n_items)
        begin
            if ($urandom_range(3) == 0) send_noise();
            else send_message();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        hold_sink      = 1'b0;
        src_idle_pct   = 17;
        snk_idle_pct   = 74;
        accepted_total = 0;
        now_ms         = 32'hFFFF_F000;
        seg_ch.valid       = 1'b0;
        seg_ch.command     = 1'b0;
        seg_ch.now_ms      = '0;
        seg_ch.ref_number  = '0;
        seg_ch.part_number = '0;
        seg_ch.total_parts = '0;
        seg_ch.sender_id   = '0;
        seg_ch.text_handle = '0;
        seg_ch.sms_time    = '0;
        seg_ch.dcs         = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        quiet_cycles       = 0;
        sender_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                        64'h5555_AAAA_5555_AAAA};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: pass-through forms, extreme fields, each DCS class,
        // a duplicate, a part beyond capacity, and an out-of-order completion.
        send_item(1'b0, 16'hFFFF, 8'd0, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF, 8'h10);
        send_item(1'b0, 16'h0000, 8'd1, 8'd1, 64'h0, 8'h13);
        send_item(1'b0, 16'h1234, 8'd255, 8'd0, 64'h1, 8'hD1);
        send_item(1'b0, 16'h1, 8'd255, 8'd255, sender_pool[2], 8'h11);
        send_item(1'b0, 16'h2, 8'd1, 8'd3, sender_pool[1], 8'h12);
        send_item(1'b0, 16'h2, 8'd1, 8'd3, sender_pool[1], 8'h12);
        send_item(1'b0, 16'h2, 8'd3, 8'd3, sender_pool[1], 8'hFF);
        send_item(1'b0, 16'h2, 8'd17, 8'd3, sender_pool[1], 8'h00);
        send_item(1'b0, 16'h2, 8'd2, 8'd3, sender_pool[1], 8'h10);
        // A two-part message delivered in order completes on its second part.
        send_item(1'b0, 16'h3, 8'd1, 8'd2, sender_pool[3], 8'h10);
        send_item(1'b0, 16'h3, 8'd2, 8'd2, sender_pool[3], 8'h10);
        // Fill all slots, then evict the oldest slot, twice.
        for (int s = 0; s < 9; s++)
        begin
            send_item(1'b0, 16'(100 + s), 8'd1, 8'd16, sender_pool[0], 8'h00);
        end
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 64'd0, 8'd0);
        write_timeout(32'd0);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 64'd0, 8'd0);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 64'd0, 8'd0);

        write_timeout(32'd5000);
        random_phase(70);

        // Long receiver hold-off while the sender keeps offering items.
        fork
            begin
                hold_sink = 1'b1;
                repeat (400) @(posedge clk);
                hold_sink = 1'b0;
            end
            random_phase(12);
        join

        // Sender pauses until every result has come back.
        drain();
        write_timeout(32'hFFFF_FFFF);
        src_idle_pct = 74;
        snk_idle_pct = 17;
        random_phase(60);
        write_timeout(32'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(60);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 64'd0, 8'd0);

        drain();
        if (fail_count == 0)
        begin
            $display("sms_concat_reassembly_table_top regression: pass");
        end
        else
        begin
            $display("sms_concat_reassembly_table_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/sms_crt_pkg.sv
src/sms_crt_ifs.sv
src/sms_crt_ram.sv
src/sms_crt_fifo.sv
src/sms_crt_front.sv
src/sms_crt_back.sv
src/sms_concat_reassembly_table_top.sv
src/sms_crt_checker.sv
tb/sv/tb_sms_crt_checker.sv
tb/sv/tb_sms_concat_reassembly_table_top.sv
